### rtl/rqcb_pkg.sv
// shared types and constants of the rotated quad command builder
package rqcb_pkg;

  localparam int COORD_W   = 16;
  localparam int GAIN_W    = 12;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int CORNERS   = 4;
  localparam int DIV_STEPS = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam int BEAT_W = 4;
  localparam logic [BEAT_W-1:0] BEAT_VTX  = 4'd0;
  localparam logic [BEAT_W-1:0] BEAT_ZERO = 4'd1;
  localparam logic [BEAT_W-1:0] BEAT_XY   = 4'd5;
  localparam logic [BEAT_W-1:0] BEAT_ST   = 4'd9;
  localparam logic [BEAT_W-1:0] BEAT_DRAW = 4'd13;

  localparam logic [31:0] CMD_VTX_LOAD = 32'h0100_4008;
  localparam logic [31:0] CMD_ZERO     = 32'h021C_0000;
  localparam logic [31:0] CMD_XY       = 32'h0218_0000;
  localparam logic [31:0] CMD_ST       = 32'h0214_0000;
  localparam logic [31:0] CMD_DRAW_HI  = 32'h0600_0402;
  localparam logic [31:0] CMD_DRAW_LO  = 32'h0000_0604;

  typedef struct packed {
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_bottom;
    logic signed [15:0] tex_s_left;
    logic signed [15:0] tex_s_right;
    logic signed [15:0] tex_t_top;
    logic signed [15:0] tex_t_bottom;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
  } rect_item_t;

  typedef struct packed {
    logic [31:0] cmd_word_high;
    logic [31:0] cmd_word_low;
    logic        last_word;
  } cmd_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] g4;
    logic [GAIN_W-1:0] g3;
  } gain_t;

  typedef struct packed {
    logic [COORD_W-1:0] s_left;
    logic [COORD_W-1:0] s_right;
    logic [COORD_W-1:0] t_top;
    logic [COORD_W-1:0] t_bottom;
  } tex_t;

  typedef struct packed {
    logic [CORNERS-1:0][2*COORD_W-1:0] xy;
    tex_t                              tex;
  } quad_t;

endpackage

### rtl/rqcb_stream_if.sv
// valid/ready stream channel with a typed payload
interface rqcb_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### rtl/rqcb_cfg.sv
// configuration registers, register read port and aspect gain selection
module rqcb_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rqcb_pkg::CFG_AW-1:0] paddr,
  input  logic [rqcb_pkg::CFG_DW-1:0] pwdata,
  output logic [rqcb_pkg::CFG_DW-1:0] prdata,
  output rqcb_pkg::gain_t            gains,
  output logic [31:0]                vtx_base
);
  import rqcb_pkg::*;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SKEW   = 2'd2;
  localparam logic [1:0] REG_BASE   = 2'd3;

  logic [9:0]  width_r;
  logic [9:0]  height_r;
  logic [15:0] skew_r;
  logic [31:0] base_r;
  gain_t       gains_r, gains_nxt;

  logic [1:0]        idx;
  logic              wr;
  logic [GAIN_W-1:0] w3, h4, adiff;
  logic [27:0]       lhs, rhs;
  logic              corr;

  assign idx = paddr[CFG_AW-1:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 10'd320;
      height_r <= 10'd240;
      skew_r   <= 16'd655;
      base_r   <= 32'd0;
      gains_r  <= '{g4: GAIN_W'(1), g3: GAIN_W'(1)};
    end else begin
      gains_r <= gains_nxt;
      if (wr) begin
        unique case (idx)
          REG_WIDTH:  width_r  <= pwdata[9:0];
          REG_HEIGHT: height_r <= pwdata[9:0];
          REG_SKEW:   skew_r   <= pwdata[15:0];
          REG_BASE:   base_r   <= pwdata[31:0];
          default:    base_r   <= base_r;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = CFG_DW'(width_r);
      REG_HEIGHT: prdata = CFG_DW'(height_r);
      REG_SKEW:   prdata = CFG_DW'(skew_r);
      REG_BASE:   prdata = CFG_DW'(base_r);
      default:    prdata = '0;
    endcase
  end

  // skew test |4h - 3w| * 2^16 > threshold * 3w
  assign w3    = GAIN_W'({2'b00, width_r}) + GAIN_W'({1'b0, width_r, 1'b0});
  assign h4    = {height_r, 2'b00};
  assign adiff = (h4 >= w3) ? (h4 - w3) : (w3 - h4);
  assign lhs   = {adiff, 16'h0000};
  assign rhs   = skew_r * w3;
  assign corr  = (width_r != 10'd0) && (height_r != 10'd0) && (lhs > rhs);

  always_comb begin
    gains_nxt.g4 = corr ? h4 : GAIN_W'(1);
    gains_nxt.g3 = corr ? w3 : GAIN_W'(1);
  end

  assign gains    = gains_r;
  assign vtx_base = base_r;

endmodule

### rtl/rqcb_div_lane.sv
// one coordinate lane: magnitude, rounding shift and radix-16 restoring divide
module rqcb_div_lane #(
  parameter int NUM_W = 49,
  parameter int SHIFT = 15,
  parameter int DEN_W = 12
) (
  input  logic                             clk,
  input  logic                             load,
  input  logic                             step,
  input  logic signed [NUM_W-1:0]          num,
  input  logic        [DEN_W-1:0]          den,
  output logic        [rqcb_pkg::COORD_W-1:0] quot
);
  import rqcb_pkg::*;

  localparam int MAG_W = NUM_W - SHIFT;
  localparam int QUO_W = ((MAG_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;

  logic             neg_r;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] mag;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : num;

  always_comb begin
    logic [DEN_W:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial   = {rem_nxt, quo_nxt[QUO_W-1]};
      quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt    = DEN_W'(trial - {1'b0, den_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= num[NUM_W-1];
      quo_r <= QUO_W'(mag[NUM_W-1:SHIFT]);
      rem_r <= '0;
      den_r <= den;
    end else if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = neg_r ? (COORD_W'(0) - quo_r[COORD_W-1:0]) : quo_r[COORD_W-1:0];

endmodule

### rtl/rqcb_front.sv
// front end: accepts rectangles, computes the four rotated corners
module rqcb_front #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rqcb_stream_if.sink           in_item,
  input  rqcb_pkg::gain_t       gains,
  output logic                  push_valid,
  output rqcb_pkg::quad_t       push_data,
  input  logic                  push_ready
);
  import rqcb_pkg::*;

  localparam int F     = TRIG_FRAC_BITS;
  localparam int CW    = COORD_W + 1;
  localparam int PRODW = CW + COORD_W;
  localparam int PW    = ((PRODW > CW + F) ? PRODW : CW + F) + 1;
  localparam int QW    = PRODW + 1;
  localparam int GW    = GAIN_W;
  localparam int MPW   = PW + GW + 1;
  localparam int MQW   = QW + GW + 1;
  localparam int NW    = ((MPW > MQW) ? MPW : MQW) + 2;
  localparam int MW    = NW - F - 1;
  localparam int DIV_CYC = (MW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DCW   = $clog2(DIV_CYC);
  localparam int NLANE = 2 * CORNERS;

  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic en2, en3, en4;

  logic signed [COORD_W-1:0] l_in, r_in, t_in, b_in;

  logic signed [CW-1:0]      d0_r, e0_r, cx0_r, cy0_r;
  logic signed [COORD_W-1:0] sn0_r, cs0_r;
  tex_t                      tex0_r, tex1_r, tex2_r, tex3_r, tex4_r, texd_r;

  logic signed [PRODW-1:0] ds1_r, es1_r, dc1_r, ec1_r;
  logic signed [PRODW-1:0] ds1_nxt, es1_nxt, dc1_nxt, ec1_nxt;
  logic signed [CW-1:0]    cx1_r, cy1_r;

  logic           dv_busy_r, dv_done_r, dv_load;
  logic [DCW-1:0] dv_cnt_r;

  logic [COORD_W-1:0] q16 [NLANE];

  assign l_in = in_item.payload.rect_left;
  assign r_in = in_item.payload.rect_right;
  assign t_in = in_item.payload.rect_top;
  assign b_in = in_item.payload.rect_bottom;

  assign dv_load = v4_r && !dv_busy_r && !dv_done_r;
  assign rdy4    = !v4_r || dv_load;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign rdy0    = !v0_r || rdy1;
  assign en2     = rdy2 && v1_r;
  assign en3     = rdy3 && v2_r;
  assign en4     = rdy4 && v3_r;

  assign in_item.ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_item.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // doubled center and doubled half extents
  always_ff @(posedge clk) begin
    if (rdy0 && in_item.valid) begin
      d0_r  <= CW'(l_in) - CW'(r_in);
      e0_r  <= CW'(t_in) - CW'(b_in);
      cx0_r <= CW'(l_in) + CW'(r_in);
      cy0_r <= CW'(t_in) + CW'(b_in);
      sn0_r <= in_item.payload.rot_sin;
      cs0_r <= in_item.payload.rot_cos;
      tex0_r.s_left   <= in_item.payload.tex_s_left;
      tex0_r.s_right  <= in_item.payload.tex_s_right;
      tex0_r.t_top    <= in_item.payload.tex_t_top;
      tex0_r.t_bottom <= in_item.payload.tex_t_bottom;
    end
  end

  assign ds1_nxt = d0_r * sn0_r;
  assign es1_nxt = e0_r * sn0_r;
  assign dc1_nxt = d0_r * cs0_r;
  assign ec1_nxt = e0_r * cs0_r;

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      ds1_r  <= ds1_nxt;
      es1_r  <= es1_nxt;
      dc1_r  <= dc1_nxt;
      ec1_r  <= ec1_nxt;
      cx1_r  <= cx0_r;
      cy1_r  <= cy0_r;
      tex1_r <= tex0_r;
    end
    if (en2) tex2_r <= tex1_r;
    if (en3) tex3_r <= tex2_r;
    if (en4) tex4_r <= tex3_r;
    if (dv_load) texd_r <= tex4_r;
  end

  // even lanes carry x, odd lanes carry y of corner j/2
  for (genvar j = 0; j < NLANE; j++) begin : g_lane
    localparam int K      = j / 2;
    localparam bit IS_Y   = (j % 2) == 1;
    localparam bit NEG_DX = (K == 1) || (K == 2);
    localparam bit NEG_DY = (K >= 2);
    localparam bit P_NEG  = IS_Y ? NEG_DY : NEG_DX;
    localparam bit Q_NEG  = IS_Y ? !NEG_DX : NEG_DY;

    logic signed [PRODW-1:0] p_src, q_src;
    logic signed [CW-1:0]    c_src;
    logic [GW-1:0]           gd, gn;
    logic signed [PW-1:0]    p_ext;
    logic signed [QW-1:0]    q_ext;
    logic signed [PW-1:0]    p2_r, p2_nxt;
    logic signed [QW-1:0]    q2_r, q2_nxt;
    logic signed [MPW-1:0]   mp3_r, mp3_nxt;
    logic signed [MQW-1:0]   mq3_r, mq3_nxt;
    logic signed [NW-1:0]    rnd;
    logic signed [NW-1:0]    n4_r, n4_nxt;

    assign p_src = IS_Y ? es1_r : ds1_r;
    assign q_src = IS_Y ? dc1_r : ec1_r;
    assign c_src = IS_Y ? cy1_r : cx1_r;
    assign gd    = IS_Y ? gains.g3 : gains.g4;
    assign gn    = IS_Y ? gains.g4 : gains.g3;

    assign p_ext   = PW'(p_src);
    assign q_ext   = QW'(q_src);
    assign p2_nxt  = (P_NEG ? -p_ext : p_ext) + (PW'(c_src) <<< F);
    assign q2_nxt  = Q_NEG ? -q_ext : q_ext;
    assign mp3_nxt = p2_r * $signed({1'b0, gd});
    assign mq3_nxt = q2_r * $signed({1'b0, gn});
    assign rnd     = {{(NW - GW - F){1'b0}}, gd, {F{1'b0}}};
    assign n4_nxt  = NW'(mp3_r) + NW'(mq3_r) + rnd;

    always_ff @(posedge clk) begin
      if (en2) begin
        p2_r <= p2_nxt;
        q2_r <= q2_nxt;
      end
      if (en3) begin
        mp3_r <= mp3_nxt;
        mq3_r <= mq3_nxt;
      end
      if (en4) n4_r <= n4_nxt;
    end

    rqcb_div_lane #(
      .NUM_W(NW),
      .SHIFT(F + 1),
      .DEN_W(GW)
    ) u_div (
      .clk  (clk),
      .load (dv_load),
      .step (dv_busy_r),
      .num  (n4_r),
      .den  (gd),
      .quot (q16[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_done_r <= 1'b0;
      dv_cnt_r  <= '0;
    end else begin
      if (dv_load) begin
        dv_busy_r <= 1'b1;
        dv_cnt_r  <= '0;
      end else if (dv_busy_r) begin
        if (dv_cnt_r == DCW'(DIV_CYC - 1)) begin
          dv_busy_r <= 1'b0;
          dv_done_r <= 1'b1;
        end else begin
          dv_cnt_r <= dv_cnt_r + DCW'(1);
        end
      end
      if (dv_done_r && push_ready) dv_done_r <= 1'b0;
    end
  end

  assign push_valid = dv_done_r;

  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      push_data.xy[k] = {q16[2*k], q16[2*k+1]};
    end
    push_data.tex = texd_r;
  end

endmodule

### rtl/rqcb_queue.sv
// short queue of finished quads between front and back
module rqcb_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rqcb_pkg::quad_t push_data,
  output logic            push_ready,
  output logic            head_valid,
  output rqcb_pkg::quad_t head,
  input  logic            pop
);
  import rqcb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  quad_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

### rtl/rqcb_back.sv
// back end: walks a quad through its fourteen command beats
module rqcb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  rqcb_pkg::quad_t head,
  input  logic [31:0]     vtx_base,
  output logic            pop,
  rqcb_stream_if.source   out_cmd
);
  import rqcb_pkg::*;

  logic [BEAT_W-1:0] cnt_r, cnt_nxt;
  logic              out_v_r;
  cmd_item_t         out_r, beat;
  logic              load;

  assign load    = head_valid && (!out_v_r || out_cmd.ready);
  assign pop     = load && (cnt_r == BEAT_DRAW);
  assign cnt_nxt = (cnt_r == BEAT_DRAW) ? BEAT_VTX : cnt_r + BEAT_W'(1);

  always_comb begin
    logic [1:0] sub;
    sub = '0;
    beat.last_word = (cnt_r == BEAT_DRAW);
    priority if (cnt_r == BEAT_VTX) begin
      beat.cmd_word_high = CMD_VTX_LOAD;
      beat.cmd_word_low  = vtx_base;
    end else if (cnt_r < BEAT_XY) begin
      sub = 2'(cnt_r - BEAT_ZERO);
      beat.cmd_word_high = CMD_ZERO + {29'd0, sub, 1'b0};
      beat.cmd_word_low  = '0;
    end else if (cnt_r < BEAT_ST) begin
      sub = 2'(cnt_r - BEAT_XY);
      beat.cmd_word_high = CMD_XY + {29'd0, sub, 1'b0};
      beat.cmd_word_low  = head.xy[sub];
    end else if (cnt_r < BEAT_DRAW) begin
      sub = 2'(cnt_r - BEAT_ST);
      beat.cmd_word_high = CMD_ST + {29'd0, sub, 1'b0};
      unique case (sub)
        2'd0:    beat.cmd_word_low = {head.tex.s_left,  head.tex.t_top};
        2'd1:    beat.cmd_word_low = {head.tex.s_right, head.tex.t_top};
        2'd2:    beat.cmd_word_low = {head.tex.s_right, head.tex.t_bottom};
        default: beat.cmd_word_low = {head.tex.s_left,  head.tex.t_bottom};
      endcase
    end else begin
      beat.cmd_word_high = CMD_DRAW_HI;
      beat.cmd_word_low  = CMD_DRAW_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= BEAT_VTX;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        cnt_r   <= cnt_nxt;
        out_v_r <= 1'b1;
      end else if (out_cmd.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= beat;
  end

  assign out_cmd.valid   = out_v_r;
  assign out_cmd.payload = out_r;

endmodule

### rtl/rotated_quad_command_builder_core.sv
// rotated quad command builder: rectangle plus sine/cosine in, fourteen command beats out
// in_item takes one rectangle per beat (edges and texture s/t as signed 16-bit values,
// rot_cos and rot_sin in signed fixed point with TRIG_FRAC_BITS fraction bits);
// out_cmd gives fourteen beats per rectangle: vertex load, four zero writes, four xy,
// four st, draw, with last_word set on the draw beat. cfg_* is an apb register port with
// screen width, height, skew threshold and vertex base at 0x0, 0x4, 0x8, 0xc.
// path from an accepted rectangle to its first beat: 5 pipeline stages, then
// the corner divider, then the queue and the output register. throughput is
// bounded by the fourteen beats of each rectangle on the single result channel;
// the front keeps accepting rectangles while the back drains beats.
// reset clears all valids and restores the register defaults (320, 240, 655, 0);
// no clearing pass. when out_cmd stalls, the output register holds its beat,
// the two-entry queue fills, and in_item.ready drops once the front is full.
module rotated_quad_command_builder_core #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rqcb_stream_if.sink                in_item,
  rqcb_stream_if.source              out_cmd,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rqcb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rqcb_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rqcb_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import rqcb_pkg::*;

  gain_t       gains;
  logic [31:0] vtx_base;
  logic        push_valid, push_ready;
  quad_t       push_data;
  logic        head_valid, pop;
  quad_t       head;

  assign cfg_pready = 1'b1;

  rqcb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .gains    (gains),
    .vtx_base (vtx_base)
  );

  rqcb_front #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .gains      (gains),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  rqcb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  rqcb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .vtx_base   (vtx_base),
    .pop        (pop),
    .out_cmd    (out_cmd)
  );

endmodule

### tb/tb_rotated_quad_command_builder_core.sv
// self-checking testbench for the rotated quad command builder core
module tb_rotated_quad_command_builder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rqcb_pkg::*;

  localparam int TRIG_FRAC = 14;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int HOLD_PHASE = 2;
  localparam int LONG_HOLD = 400;
  localparam int MAX_REPORTS = 20;

  typedef enum logic [CFG_AW-1:0] {
    REG_SCREEN_WIDTH   = 4'h0,
    REG_SCREEN_HEIGHT  = 4'h4,
    REG_SKEW_THRESHOLD = 4'h8,
    REG_VERTEX_BASE    = 4'hC
  } cfg_reg_e;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_EVERY_THIRD,
    STALL_RARE
  } stall_mode_e;

  class quad_cmd_scoreboard;
    cmd_item_t   pending[$];
    logic [9:0]  width;
    logic [9:0]  height;
    logic [15:0] skew_thr;
    logic [31:0] vtx_base;
    int          mismatches;
    int          rects;
    int          beats;

    function new();
      width = 10'd320;
      height = 10'd240;
      skew_thr = 16'd655;
      vtx_base = '0;
      mismatches = 0;
      rects = 0;
      beats = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] v);
      case (idx)
        REG_SCREEN_WIDTH:   width = v[9:0];
        REG_SCREEN_HEIGHT:  height = v[9:0];
        REG_SKEW_THRESHOLD: skew_thr = v[15:0];
        REG_VERTEX_BASE:    vtx_base = v;
        default: ;
      endcase
    endfunction

    static function logic [15:0] round_half_up(longint num, longint den);
      longint q;
      q = (2 * num + den) / (2 * den);
      return 16'(q);
    endfunction

    function void push_beat(logic [31:0] hi, logic [31:0] lo, logic last);
      cmd_item_t c;
      c.cmd_word_high = hi;
      c.cmd_word_low = lo;
      c.last_word = last;
      pending.push_back(c);
    endfunction

    function void note_rect(rect_item_t r);
      longint one, w, h, xn, xd, yn, yd, l, rt, t, b, cx2, cy2, sn, cs, diff, dx, dy;
      longint xnum, ynum;
      longint dxs[4];
      longint dys[4];
      logic [15:0] x, y;
      rects++;
      one = longint'(1) << TRIG_FRAC;
      w = longint'(width);
      h = longint'(height);
      l = longint'($signed(r.rect_left));
      rt = longint'($signed(r.rect_right));
      t = longint'($signed(r.rect_top));
      b = longint'($signed(r.rect_bottom));
      cs = longint'($signed(r.rot_cos));
      sn = longint'($signed(r.rot_sin));
      cx2 = l + rt;
      cy2 = t + b;
      xn = 1;
      xd = 1;
      yn = 1;
      yd = 1;
      if (w != 0 && h != 0) begin
        diff = 4 * h - 3 * w;
        if (diff < 0) diff = -diff;
        if (diff * 65536 > longint'(skew_thr) * 3 * w) begin
          xn = 3 * w;
          xd = 4 * h;
          yn = 4 * h;
          yd = 3 * w;
        end
      end
      // doubled corner offsets: left-top, right-top, right-bottom, left-bottom
      dxs[0] = l - rt; dys[0] = t - b;
      dxs[1] = rt - l; dys[1] = t - b;
      dxs[2] = rt - l; dys[2] = b - t;
      dxs[3] = l - rt; dys[3] = b - t;

      push_beat(CMD_VTX_LOAD, vtx_base, 1'b0);
      for (int k = 0; k < CORNERS; k++) push_beat(CMD_ZERO + 32'(2 * k), '0, 1'b0);
      for (int k = 0; k < CORNERS; k++) begin
        dx = dxs[k];
        dy = dys[k];
        xnum = dx * sn * xd + cx2 * one * xd + dy * cs * xn;
        ynum = dy * sn * yd + cy2 * one * yd - dx * cs * yn;
        x = round_half_up(xnum, 2 * one * xd);
        y = round_half_up(ynum, 2 * one * yd);
        push_beat(CMD_XY + 32'(2 * k), {x, y}, 1'b0);
      end
      push_beat(CMD_ST + 32'd0, {r.tex_s_left, r.tex_t_top}, 1'b0);
      push_beat(CMD_ST + 32'd2, {r.tex_s_right, r.tex_t_top}, 1'b0);
      push_beat(CMD_ST + 32'd4, {r.tex_s_right, r.tex_t_bottom}, 1'b0);
      push_beat(CMD_ST + 32'd6, {r.tex_s_left, r.tex_t_bottom}, 1'b0);
      push_beat(CMD_DRAW_HI, CMD_DRAW_LO, 1'b1);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
    endtask

    task check_cmd(cmd_item_t got);
      cmd_item_t exp_c;
      beats++;
      if (pending.size() == 0) begin
        report("beat with nothing outstanding", got.cmd_word_high, '0);
        return;
      end
      exp_c = pending.pop_front();
      if (got.cmd_word_high !== exp_c.cmd_word_high)
        report("cmd_word_high", got.cmd_word_high, exp_c.cmd_word_high);
      if (got.cmd_word_low !== exp_c.cmd_word_low)
        report("cmd_word_low", got.cmd_word_low, exp_c.cmd_word_low);
      if (got.last_word !== exp_c.last_word)
        report("last_word", 32'(got.last_word), 32'(exp_c.last_word));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  rqcb_stream_if #(.payload_t(rect_item_t)) rect_ch ();
  rqcb_stream_if #(.payload_t(cmd_item_t)) cmd_ch ();

  quad_cmd_scoreboard sb = new();
  bit hold_req = 1'b0;
  int burst_left = 0;
  int settings_used = 0;

  rotated_quad_command_builder_core #(.TRIG_FRAC_BITS(TRIG_FRAC)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_item(rect_ch),
    .out_cmd(cmd_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (rect_ch.valid && rect_ch.ready) sb.note_rect(rect_ch.payload);
      if (cmd_ch.valid && cmd_ch.ready) sb.check_cmd(cmd_ch.payload);
    end
  end

  // receiver: random stall modes, plus one long hold on request
  initial begin
    int hold_left;
    int mode_left;
    int cyc;
    stall_mode_e mode;
    hold_left = 0;
    mode_left = 0;
    cyc = 0;
    mode = STALL_NONE;
    cmd_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (!rst_n) begin
        cmd_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        cmd_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          STALL_NONE:        cmd_ch.ready <= 1'b1;
          STALL_COIN:        cmd_ch.ready <= 1'($urandom_range(0, 1));
          STALL_EVERY_THIRD: cmd_ch.ready <= (cyc % 3 != 0);
          default:           cmd_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= idx;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_all(logic [9:0] w, logic [9:0] h, logic [15:0] thr, logic [31:0] base);
    write_reg(REG_SCREEN_WIDTH, 32'(w));
    write_reg(REG_SCREEN_HEIGHT, 32'(h));
    write_reg(REG_SKEW_THRESHOLD, 32'(thr));
    write_reg(REG_VERTEX_BASE, base);
    settings_used++;
  endtask

  task automatic apply_setting(int p);
    longint w, h, diff, bound;
    w = $urandom_range(1, 1023);
    h = $urandom_range(1, 1023);
    diff = 4 * h - 3 * w;
    if (diff < 0) diff = -diff;
    // threshold right at the skew boundary
    bound = (diff * 65536) / (3 * w) + $urandom_range(0, 2) - 1;
    if (bound < 0) bound = 0;
    if (bound > 65535) bound = 65535;
    case (p)
      0: set_all(10'd320, 10'd240, 16'd0, 32'hDEAD_BEEF);
      1: set_all(10'd640, 10'd240, 16'd655, 32'hFFFF_FFFF);
      2: set_all(10'd1, 10'd1023, 16'hFFFF, 32'h0);
      3: set_all(10'd1023, 10'd1, 16'd0, 32'h1234_5678);
      4: set_all(10'd0, 10'd480, 16'd655, $urandom);
      5: set_all(10'd1023, 10'd1023, 16'($urandom), $urandom);
      6: set_all(10'(w), 10'(h), 16'(bound), $urandom);
      default: set_all(10'(w), 10'(h), 16'($urandom_range(0, 65535)), $urandom);
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_rect(rect_item_t r, bit steady);
    int gap;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          rect_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    rect_ch.valid <= 1'b1;
    rect_ch.payload <= r;
    do @(posedge clk); while (!rect_ch.ready);
  endtask

  function automatic rect_item_t mk_rect(logic [15:0] l, logic [15:0] r, logic [15:0] t,
                                         logic [15:0] b, logic [15:0] sl, logic [15:0] sr,
                                         logic [15:0] tt, logic [15:0] tb, logic [15:0] cs,
                                         logic [15:0] sn);
    return {l, r, t, b, sl, sr, tt, tb, cs, sn};
  endfunction

  function automatic rect_item_t random_rect();
    rect_item_t r;
    real ang;
    if ($urandom_range(0, 3) == 0) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      r.rect_left = 16'($urandom_range(0, 1400)) - 16'd200;
      r.rect_right = r.rect_left + 16'($urandom_range(0, 600));
      r.rect_top = 16'($urandom_range(0, 1100)) - 16'd150;
      r.rect_bottom = r.rect_top + 16'($urandom_range(0, 500));
      r.tex_s_left = 16'($urandom);
      r.tex_s_right = 16'($urandom);
      r.tex_t_top = 16'($urandom);
      r.tex_t_bottom = 16'($urandom);
      ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
      r.rot_cos = 16'($rtoi(16384.0 * $cos(ang)));
      r.rot_sin = 16'($rtoi(16384.0 * $sin(ang)));
    end
    return r;
  endfunction

  initial begin
    rect_item_t dir_q[$];
    rst_n <= 1'b0;
    rect_ch.valid <= 1'b0;
    rect_ch.payload <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, every rotation quadrant, odd centers, out-of-range trig
    dir_q.push_back(mk_rect(0, 0, 0, 0, 0, 0, 0, 0, 16'sd16384, 0));
    dir_q.push_back(mk_rect(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000));
    dir_q.push_back(mk_rect(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    dir_q.push_back(mk_rect(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 16'h8000,
                            16'h7FFF, 16'sd16384, 16'sd16384));
    dir_q.push_back(mk_rect(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 16'hFFFF, 16'h7FFF,
                            16'h8000, -16'sd16384, -16'sd16384));
    dir_q.push_back(mk_rect(10, 20, 30, 40, 1, 2, 3, 4, 16'h8000, 16'h7FFF));
    dir_q.push_back(mk_rect(10, 20, 30, 40, 5, 6, 7, 8, 16'h7FFF, 16'h8000));
    dir_q.push_back(mk_rect(100, 50, 80, 20, 11, 22, 33, 44, 16'sd16384, 0));
    dir_q.push_back(mk_rect(0, 1, 0, 3, 0, 16'h100, 0, 16'h100, 0, 16'sd16384));
    dir_q.push_back(mk_rect(-16'sd1, 0, -16'sd3, 0, 0, 0, 0, 0, 0, 16'sd16384));
    dir_q.push_back(mk_rect(-16'sd7, -16'sd2, -16'sd9, -16'sd4, 0, 0, 0, 0, 0, -16'sd16384));
    dir_q.push_back(mk_rect(0, 320, 0, 240, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 1, -16'sd1));
    dir_q.push_back(mk_rect(100, 200, 50, 150, 0, 16'h4000, 0, 16'h4000, 11585, 11585));
    dir_q.push_back(mk_rect(100, 200, 50, 150, 0, 16'h4000, 0, 16'h4000, -16'sd11585, 11585));
    dir_q.push_back(mk_rect(100, 200, 50, 150, 0, 16'h4000, 0, 16'h4000, -16'sd11585,
                            -16'sd11585));
    dir_q.push_back(mk_rect(100, 200, 50, 150, 0, 16'h4000, 0, 16'h4000, 11585, -16'sd11585));
    dir_q.push_back(mk_rect(-16'sd300, 301, -16'sd17, 18, 16'h1234, 16'h5678, 16'h9ABC,
                            16'hDEF0, 14189, 8192));
    dir_q.push_back(mk_rect(16'h7FFE, 16'h7FFF, 16'h8001, 16'h8000, 0, 0, 0, 0, 16'h7FFF,
                            16'h7FFF));
    dir_q.push_back(mk_rect(16'h8000, 16'h8001, 16'h7FFF, 16'h7FFE, 0, 0, 0, 0, 16'h8000,
                            16'h8000));
    dir_q.push_back(mk_rect(5, 6, 7, 8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0));
    foreach (dir_q[i]) send_rect(dir_q[i], 1'b0);
    rect_ch.valid <= 1'b0;
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      apply_setting(p);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_rect(random_rect(), p == HOLD_PHASE);
      rect_ch.valid <= 1'b0;
      wait_idle();
    end
    repeat (30) @(posedge clk);

    $display("checked %0d rectangles and %0d command beats under %0d register settings",
             sb.rects, sb.beats, settings_used + 1);
    $display("with bursty input, random output stalls and one %0d-cycle output hold",
             LONG_HOLD);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
